[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module of the allocator.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/ffpa_pkg.sv]
// Package of the first-fit pool allocator: port widths, default sizes,
// operation codes and the controller state type. Depends on nothing.
package ffpa_pkg;

	localparam int POOL_BYTES_DEF   = 1024;
	localparam int HEADER_BYTES_DEF = 24;

	localparam int REQ_W      = 10;
	localparam int OFF_W      = 10;
	localparam int S_TDATA_W  = 24;
	localparam int S_TUSER_W  = 1;
	localparam int M_TDATA_W  = 16;
	localparam int M_TUSER_W  = 1;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_CHK,
		ST_A_SPLIT,
		ST_R_MOD,
		ST_M_START,
		ST_M_CUR,
		ST_M_NX,
		ST_RESP
	} state_t;

endpackage

[rtl/core/ffpa_hdr_ram.sv]
// Header store of the allocator: one write port, one read port with
// registered read data. Depends on nothing.
module ffpa_hdr_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 21
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/first_fit_pool_allocator.sv]
// Top level of the first-fit pool allocator: controller, datapath and output register.
// Depends on ffpa_pkg and ffpa_hdr_ram.
//
// The block manages a pool of POOL_BYTES bytes as a chain of blocks in address
// order. Every block starts with a header of HEADER_BYTES bytes holding its
// payload size, the offset of the next header (zero ends the chain) and a free
// mark; the headers live in a memory with one entry per byte offset. One word
// on the input stream is one request: an allocate walks the chain from offset 0
// to the first free block that is large enough, marks it used, splits off the
// tail as a new free block when more than a header is left over, and returns
// the payload offset (op_ok low and offset zero when nothing fits). A release
// of a payload offset marks that header free and makes one merge pass over the
// chain, joining each free block with a free successor and then moving past
// the joined block. Releases of null, of offsets below one header or outside
// the pool are ignored and still answered with op_ok high. Requests are worked
// one at a time. The cost is set by the header memory, which returns one
// header per cycle: an allocate reads the headers up to the hit or the chain
// end and, when the block is split, writes the new free header in a further
// step. A release writes the free mark and then makes the merge pass, which
// reads the header of each block that it stands on and one more for each free
// block that has a successor to look at. An ignored release goes straight to
// its answer. A new request is taken as soon as the previous one has moved
// its result into the output register, even if that result has not been
// taken yet. After reset the block writes the initial free header before it
// takes a request.
module first_fit_pool_allocator #(
	parameter int POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
	parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0 up: request_size[9:0], release_address[19:10], zero pad.
	input  logic [ffpa_pkg::S_TDATA_W-1:0] s_tdata,
	// Fields from bit 0 up: func (0 allocate, 1 release).
	input  logic [ffpa_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0 up: payload_offset[9:0], zero pad.
	output logic [ffpa_pkg::M_TDATA_W-1:0] m_tdata,
	// Fields from bit 0 up: op_ok.
	output logic [ffpa_pkg::M_TUSER_W-1:0] m_tuser
);

	import ffpa_pkg::*;

	// Header entry layout: size in the low bits, then link, then free mark.
	localparam int AW       = $clog2(POOL_BYTES);
	localparam int EW       = 2 * AW + 1;
	localparam int LINK_LO  = AW;
	localparam int FREE_BIT = 2 * AW;
	localparam int CW       = ((AW > REQ_W) ? AW : REQ_W) + 1;

	localparam logic [CW-1:0] HB_C   = CW'(HEADER_BYTES);
	localparam logic [CW-1:0] POOL_C = CW'(POOL_BYTES);
	localparam logic [AW-1:0] INIT_SIZE = AW'(POOL_BYTES - HEADER_BYTES);

	state_t state_q, state_d;

	// Datapath registers.
	logic [AW-1:0]    cur_q, cur_d;
	logic [EW-1:0]    cur_ent_q, cur_ent_d;
	logic [AW-1:0]    split_addr_q, split_addr_d;
	logic [EW-1:0]    split_ent_q, split_ent_d;
	logic [REQ_W-1:0] req_q, req_d;
	logic [AW-1:0]    rel_h_q, rel_h_d;
	logic             rslt_ok_q, rslt_ok_d;
	logic [OFF_W-1:0] rslt_off_q, rslt_off_d;

	// Output register.
	logic             out_valid_q;
	logic             out_ok_q;
	logic [OFF_W-1:0] out_off_q;
	logic             out_load;

	// Header memory ports.
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	// Request fields.
	logic             in_fire;
	logic             in_func;
	logic [REQ_W-1:0] in_req;
	logic [OFF_W-1:0] in_addr;
	logic [CW-1:0]    in_addr_ext;
	logic [CW-1:0]    in_h_ext;
	logic             rel_valid;

	// Fields of the header that the memory returns this cycle and of the one held in cur_ent_q.
	logic          rd_free;
	logic [AW-1:0] rd_link;
	logic [AW-1:0] rd_size;
	logic [AW-1:0] cur_link;
	logic [AW-1:0] cur_size;

	// Decisions shared by the next-state logic and the memory and datapath logic.
	logic          alloc_fit;
	logic          alloc_split;
	logic [AW-1:0] split_addr;
	logic [AW-1:0] split_size;
	logic [AW-1:0] merge_size;
	logic [AW-1:0] merge_next;
	logic          cur_look_nx;

	assign in_func     = s_tuser[0];
	assign in_req      = s_tdata[REQ_W-1:0];
	assign in_addr     = s_tdata[REQ_W+OFF_W-1:REQ_W];
	assign in_fire     = s_tvalid && s_tready;
	assign in_addr_ext = CW'(in_addr);
	assign in_h_ext    = in_addr_ext - HB_C;
	// An offset of zero is below one header as well, so one compare covers null.
	assign rel_valid   = (in_addr_ext >= HB_C) && (in_h_ext < POOL_C);

	assign rd_free  = ram_rdata[FREE_BIT];
	assign rd_link  = ram_rdata[LINK_LO +: AW];
	assign rd_size  = ram_rdata[0 +: AW];
	assign cur_link = cur_ent_q[LINK_LO +: AW];
	assign cur_size = cur_ent_q[0 +: AW];

	assign alloc_fit   = rd_free && (CW'(rd_size) >= CW'(req_q));
	assign alloc_split = CW'(rd_size) > (CW'(req_q) + HB_C);
	assign split_addr  = AW'(CW'(cur_q) + HB_C + CW'(req_q));
	assign split_size  = AW'(CW'(rd_size) - CW'(req_q) - HB_C);
	assign merge_size  = AW'(CW'(cur_size) + CW'(rd_size) + HB_C);
	// After a merge the pass skips to the block behind the absorbed one.
	assign merge_next  = rd_free ? rd_link : cur_link;
	assign cur_look_nx = rd_free && (rd_link != '0);

	assign out_load = !out_valid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					if (in_func == FUNC_ALLOC) begin
						state_d = ST_A_CHK;
					end else if (rel_valid) begin
						state_d = ST_R_MOD;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_A_CHK: begin
				if (alloc_fit) begin
					state_d = alloc_split ? ST_A_SPLIT : ST_RESP;
				end else if (rd_link == '0) begin
					state_d = ST_RESP;
				end
			end
			ST_A_SPLIT: begin
				state_d = ST_RESP;
			end
			ST_R_MOD: begin
				state_d = ST_M_START;
			end
			ST_M_START: begin
				state_d = ST_M_CUR;
			end
			ST_M_CUR: begin
				if (cur_look_nx) begin
					state_d = ST_M_NX;
				end else if (rd_link == '0) begin
					state_d = ST_RESP;
				end
			end
			ST_M_NX: begin
				state_d = (merge_next == '0) ? ST_RESP : ST_M_CUR;
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// Memory controls and datapath updates.
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = '0;
		ram_wdata    = '0;
		ram_re       = 1'b0;
		ram_raddr    = '0;
		cur_d        = cur_q;
		cur_ent_d    = cur_ent_q;
		split_addr_d = split_addr_q;
		split_ent_d  = split_ent_q;
		req_d        = req_q;
		rel_h_d      = rel_h_q;
		rslt_ok_d    = rslt_ok_q;
		rslt_off_d   = rslt_off_q;
		s_tready     = 1'b0;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = {1'b1, {AW{1'b0}}, INIT_SIZE};
			end
			ST_IDLE: begin
				s_tready   = 1'b1;
				req_d      = in_req;
				rel_h_d    = AW'(in_h_ext);
				cur_d      = '0;
				rslt_ok_d  = 1'b1;
				rslt_off_d = '0;
				if (in_fire) begin
					if (in_func == FUNC_ALLOC) begin
						ram_re    = 1'b1;
						ram_raddr = '0;
					end else if (rel_valid) begin
						ram_re    = 1'b1;
						ram_raddr = AW'(in_h_ext);
					end
				end
			end
			ST_A_CHK: begin
				if (alloc_fit) begin
					ram_we     = 1'b1;
					ram_waddr  = cur_q;
					ram_wdata  = alloc_split ? {1'b0, split_addr, AW'(req_q)}
					                         : {1'b0, rd_link, rd_size};
					split_addr_d = split_addr;
					split_ent_d  = {1'b1, rd_link, split_size};
					rslt_ok_d    = 1'b1;
					rslt_off_d   = OFF_W'(CW'(cur_q) + HB_C);
				end else if (rd_link == '0) begin
					rslt_ok_d  = 1'b0;
					rslt_off_d = '0;
				end else begin
					cur_d     = rd_link;
					ram_re    = 1'b1;
					ram_raddr = rd_link;
				end
			end
			ST_A_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = split_addr_q;
				ram_wdata = split_ent_q;
			end
			ST_R_MOD: begin
				ram_we    = 1'b1;
				ram_waddr = rel_h_q;
				ram_wdata = {1'b1, ram_rdata[FREE_BIT-1:0]};
			end
			ST_M_START: begin
				// Read in the cycle after the free mark went in, so a release at
				// offset zero is seen by the pass.
				cur_d     = '0;
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			ST_M_CUR: begin
				cur_ent_d = ram_rdata;
				if (cur_look_nx) begin
					ram_re    = 1'b1;
					ram_raddr = rd_link;
				end else if (rd_link != '0) begin
					cur_d     = rd_link;
					ram_re    = 1'b1;
					ram_raddr = rd_link;
				end
			end
			ST_M_NX: begin
				// The successor always lies above the current block, so the
				// write and the next read never meet at one entry.
				if (rd_free) begin
					ram_we    = 1'b1;
					ram_waddr = cur_q;
					ram_wdata = {1'b1, rd_link, merge_size};
				end
				if (merge_next != '0) begin
					cur_d     = merge_next;
					ram_re    = 1'b1;
					ram_raddr = merge_next;
				end
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		cur_ent_q    <= cur_ent_d;
		split_addr_q <= split_addr_d;
		split_ent_q  <= split_ent_d;
		req_q        <= req_d;
		rel_h_q      <= rel_h_d;
		rslt_ok_q    <= rslt_ok_d;
		rslt_off_q   <= rslt_off_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_load) begin
			out_ok_q  <= rslt_ok_q;
			out_off_q <= rslt_off_q;
		end
	end

	ffpa_hdr_ram #(
		.DEPTH (POOL_BYTES),
		.WIDTH (EW)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_off_q);
	assign m_tuser  = M_TUSER_W'(out_ok_q);

endmodule

[rtl/core/ffpa_checker.sv]
// Port-level checker of the first-fit pool allocator and its bind statement.
// Depends on ffpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffpa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ffpa_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [ffpa_pkg::M_TUSER_W-1:0] m_tuser
);

	import ffpa_pkg::*;

	// A result word that is not taken stays put.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Requests are worked one at a time: the input closes after each accepted word.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// A failed allocation reports a zero offset.
	`ASSERT_IMPLIES(a_fail_zero, clk, arst_n, m_tvalid && (m_tuser[0] == 1'b0), m_tdata == '0)

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (.*);

[sim/first_fit_pool_allocator_tb.sv]
// Self-checking testbench of the first-fit pool allocator: a scoreboard class that
// mirrors the header chain and predicts every result word, plus plain driver tasks.
// Depends on ffpa_pkg and the first_fit_pool_allocator RTL.
`timescale 1ns / 100ps

// One result word as the scoreboard sees it.
typedef struct packed {
	logic                      ok;
	logic [ffpa_pkg::OFF_W-1:0] off;
} alloc_reply_t;

class alloc_scoreboard;
	localparam int unsigned POOL = ffpa_pkg::POOL_BYTES_DEF;
	localparam int unsigned HDR  = ffpa_pkg::HEADER_BYTES_DEF;

	int unsigned  hdr_size[POOL];
	int unsigned  hdr_link[POOL];
	bit           hdr_free[POOL];
	alloc_reply_t reply_q[$];
	int           mismatches;

	function new();
		foreach (hdr_size[i]) begin
			hdr_size[i] = 0;
			hdr_link[i] = 0;
			hdr_free[i] = 1'b0;
		end
		hdr_size[0] = POOL - HDR;
		hdr_free[0] = 1'b1;
		mismatches  = 0;
	endfunction

	// Walk from offset 0 to the first free block that is large enough.
	function alloc_reply_t first_fit(int unsigned req);
		int unsigned  cur;
		int unsigned  guard;
		int unsigned  nb;
		alloc_reply_t r;
		r     = '0;
		cur   = 0;
		guard = 0;
		while (cur < POOL && guard <= POOL) begin
			guard++;
			if (hdr_free[cur] && hdr_size[cur] >= req) begin
				hdr_free[cur] = 1'b0;
				if (hdr_size[cur] > req + HDR) begin
					nb = cur + HDR + req;
					if (nb < POOL) begin
						hdr_size[nb]  = hdr_size[cur] - req - HDR;
						hdr_link[nb]  = hdr_link[cur];
						hdr_free[nb]  = 1'b1;
						hdr_link[cur] = nb;
						hdr_size[cur] = req;
					end
				end
				r.ok  = 1'b1;
				r.off = ffpa_pkg::OFF_W'((cur + HDR) & 32'h3FF);
				return r;
			end
			cur = hdr_link[cur];
			if (cur == 0)
				break;
		end
		return r;
	endfunction

	// One pass over the chain; after a join it moves past the joined block.
	function void coalesce_pass();
		int unsigned cur;
		int unsigned guard;
		int unsigned nx;
		cur   = 0;
		guard = 0;
		while (cur < POOL && guard <= POOL) begin
			guard++;
			nx = hdr_link[cur];
			if (hdr_free[cur] && nx != 0 && nx < POOL && hdr_free[nx]) begin
				hdr_size[cur] = hdr_size[cur] + hdr_size[nx] + HDR;
				hdr_link[cur] = hdr_link[nx];
			end
			cur = hdr_link[cur];
			if (cur == 0)
				break;
		end
	endfunction

	// Called for every accepted request word; returns the predicted reply.
	function alloc_reply_t note_request(logic func, logic [9:0] req, logic [9:0] addr);
		alloc_reply_t r;
		int unsigned  h;
		if (func == ffpa_pkg::FUNC_ALLOC) begin
			r = first_fit(int'(req));
		end else begin
			r.ok  = 1'b1;
			r.off = '0;
			if (addr != 0 && addr >= HDR) begin
				h = int'(addr) - HDR;
				if (h < POOL) begin
					hdr_free[h] = 1'b1;
					coalesce_pass();
				end
			end
		end
		reply_q.push_back(r);
		return r;
	endfunction

	function void flag(string what, alloc_reply_t exp_r, alloc_reply_t act_r);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected ok=%0b off=%0d, got ok=%0b off=%0d", $realtime, what,
				exp_r.ok, exp_r.off, act_r.ok, act_r.off);
	endfunction

	// Called for every accepted result word.
	function void check_reply(logic ok, logic [9:0] off);
		alloc_reply_t act_r;
		alloc_reply_t exp_r;
		act_r.ok  = ok;
		act_r.off = off;
		if (reply_q.size() == 0) begin
			flag("result word with nothing expected", '0, act_r);
			return;
		end
		exp_r = reply_q.pop_front();
		if (exp_r.ok !== act_r.ok)
			flag("op_ok differs", exp_r, act_r);
		else if (exp_r.off !== act_r.off)
			flag("payload_offset differs", exp_r, act_r);
	endfunction

	function int pending();
		return reply_q.size();
	endfunction
endclass

module first_fit_pool_allocator_tb;
	import ffpa_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	alloc_scoreboard sb = new();

	// Payload offsets that are currently granted; the random part releases from here.
	logic [9:0] live_q[$];

	// While set, neither side idles.
	bit calm = 1'b0;

	first_fit_pool_allocator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no gap or a short one, now and then a long one; no gap while calm is set.
	function automatic int idle_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Present one request word and hold it until the block takes it. The task is
	// entered and left right after a rising edge, so every drive is an NBA there.
	// tvalid is left high so that a back-to-back word needs no second assignment.
	task automatic send_word(input logic func, input logic [9:0] req, input logic [9:0] addr);
		int           gap;
		alloc_reply_t r;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {{(S_TDATA_W - 20){1'b0}}, addr, req};
		do @(posedge clk); while (!s_tready);
		r = sb.note_request(func, req, addr);
		// Keep the list of granted offsets in step with the prediction.
		if (func == FUNC_ALLOC && r.ok)
			live_q.push_back(r.off);
		if (func == FUNC_RELEASE) begin
			for (int i = 0; i < live_q.size(); i++) begin
				if (live_q[i] == addr) begin
					live_q.delete(i);
					break;
				end
			end
		end
	endtask

	// Stop sending until every predicted reply has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Hand-picked sequence. The chain is tracked in the comments so that each
	// step lands on the intended corner.
	task automatic directed_part();
		send_word(FUNC_ALLOC, 10'd0, 10'd0);         // Zero-byte request, split at 24.
		send_word(FUNC_ALLOC, 10'd1023, 10'd1023);   // Nothing is that large.
		send_word(FUNC_ALLOC, 10'd100, 10'd0);       // Granted at 48.
		send_word(FUNC_ALLOC, 10'd40, 10'd0);        // Granted at 172.
		send_word(FUNC_RELEASE, 10'd0, 10'd0);       // Null release.
		send_word(FUNC_RELEASE, 10'd1023, 10'd1);    // Below one header.
		send_word(FUNC_RELEASE, 10'd512, 10'd23);    // Last offset below one header.
		send_word(FUNC_RELEASE, 10'd0, 10'd1023);    // Header offset 999 is no block.
		send_word(FUNC_RELEASE, 10'd0, 10'd500);     // Another address inside a payload.
		send_word(FUNC_RELEASE, 10'd0, 10'd48);      // Real block.
		send_word(FUNC_RELEASE, 10'd0, 10'd48);      // Same block again, already free.
		send_word(FUNC_RELEASE, 10'd0, 10'd24);      // Joins with its free successor.
		send_word(FUNC_ALLOC, 10'd124, 10'd0);       // Exact fit, no split.
		send_word(FUNC_ALLOC, 10'd1000, 10'd0);      // Too large while blocks are used.
		send_word(FUNC_ALLOC, 10'd788, 10'd0);       // Exact fit of the tail block.
		send_word(FUNC_ALLOC, 10'd0, 10'd0);         // Pool is full.
		send_word(FUNC_RELEASE, 10'd0, 10'd236);
		send_word(FUNC_RELEASE, 10'd0, 10'd172);
		send_word(FUNC_RELEASE, 10'd0, 10'd24);      // Whole pool is one block again.
		send_word(FUNC_ALLOC, 10'd1000, 10'd0);      // Largest possible grant.
		send_word(FUNC_RELEASE, 10'd0, 10'd24);
		send_word(FUNC_ALLOC, 10'd975, 10'd0);       // Split leaves a one-byte block at 999.
		send_word(FUNC_ALLOC, 10'd1, 10'd0);         // Highest payload offset, 1023.
		send_word(FUNC_RELEASE, 10'd0, 10'd1023);
		send_word(FUNC_RELEASE, 10'd0, 10'd24);
	endtask

	// Most words are sensible allocates and releases of granted offsets; about
	// one in ten is noise. The field a request does not use gets random bits.
	task automatic random_word();
		int         pick;
		int         idx;
		logic [9:0] junk;
		logic [9:0] sz;
		pick = $urandom_range(0, 99);
		junk = 10'($urandom);
		if (pick < 10) begin
			case ($urandom_range(0, 3))
				0: begin
					send_word(FUNC_RELEASE, junk, 10'($urandom_range(0, 1023)));
				end
				1: begin
					send_word(FUNC_RELEASE, junk, 10'($urandom_range(0, HEADER_BYTES_DEF - 1)));
				end
				2: begin
					send_word(FUNC_ALLOC, 10'($urandom_range(0, 1023)), junk);
				end
				default: begin
					send_word(FUNC_RELEASE, junk, 10'($urandom_range(HEADER_BYTES_DEF, 1023)));
				end
			endcase
		end else if (live_q.size() == 0 || pick < 55) begin
			// Small requests keep the chain long; a few large ones hit the top end.
			case ($urandom_range(0, 9))
				0:       sz = 10'($urandom_range(0, 1023));
				1, 2:    sz = 10'($urandom_range(81, 400));
				default: sz = 10'($urandom_range(0, 80));
			endcase
			send_word(FUNC_ALLOC, sz, junk);
		end else begin
			idx = $urandom_range(0, live_q.size() - 1);
			send_word(FUNC_RELEASE, junk, live_q[idx]);
		end
	endtask

	// Result side: takes a word at every edge where valid meets ready, and stalls
	// at random in between. m_tready gets exactly one assignment per edge.
	initial begin
		int stall;
		stall    = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_reply(m_tuser[0], m_tdata[9:0]);
			if (stall > 0 && !calm) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 99) < 25)
					stall = idle_gap();
			end
		end
	end

	// Request side and end of run.
	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_part();
		// Let the block run dry once before the random traffic starts.
		drain();

		repeat (200) random_word();
		drain();

		// A stretch with neither side idling.
		calm = 1'b1;
		repeat (100) random_word();
		drain();
		calm = 1'b0;

		repeat (200) random_word();
		drain();

		// Wait out a release's merge pass over the whole chain, so anything stray shows up here.
		repeat (300) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[first_fit_pool_allocator.f]
+incdir+rtl/core
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_hdr_ram.sv
rtl/core/first_fit_pool_allocator.sv
rtl/core/ffpa_checker.sv
sim/first_fit_pool_allocator_tb.sv
